// ===== hw/rtl/emg_envelope_baseline_tracker_assert.svh =====
// Assertion macros for the EMG envelope and baseline tracker.
`ifndef EMG_ENVELOPE_BASELINE_TRACKER_ASSERT_SVH
`define EMG_ENVELOPE_BASELINE_TRACKER_ASSERT_SVH

// Checked on every rising edge, ignored while reset is held.
`define EBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define EBT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/emgebt_pkg.sv =====
// Shared types and fixed constants of the EMG envelope and baseline tracker.
`default_nettype none

package emgebt_pkg;

  localparam int unsigned RAW_W  = 16;
  localparam int unsigned CODE_W = 14;
  localparam int unsigned SUM_W  = 18;
  localparam int unsigned VAL_W  = 22;
  localparam int unsigned Q_W    = 16;

  localparam logic [RAW_W-1:0] OFFSET_RST = 16'd8191;

  // Q16 weights of 0.99 and 0.01, and the rounding half
  localparam logic [Q_W-1:0] W_OLD      = 16'd64881;
  localparam logic [Q_W-1:0] W_NEW      = 16'd655;
  localparam logic [Q_W-1:0] ROUND_HALF = 16'h8000;

  typedef struct packed {
    logic [RAW_W-1:0] raw_channel_a;
    logic [RAW_W-1:0] raw_channel_b;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] envelope_a;
    logic [VAL_W-1:0] envelope_b;
    logic [VAL_W-1:0] baseline_a;
    logic [VAL_W-1:0] baseline_b;
  } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/emgebt_track.sv =====
// Per-channel envelope smoothing and adaptive baseline state.
`default_nettype none

module emgebt_track import emgebt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             upd_i,
  input  wire logic [VAL_W-1:0] mean_i,
  output logic      [VAL_W-1:0] env_o,
  output logic      [VAL_W-1:0] base_o
);

  localparam int unsigned BL_W = VAL_W + Q_W + 1;

  logic [VAL_W-1:0] smooth_q, smooth_d;
  logic [VAL_W-1:0] floor_q, floor_d;
  logic [VAL_W:0]   env_sum;
  logic [BL_W-1:0]  blend;

  always_comb begin
    env_sum  = {1'b0, smooth_q} + {1'b0, mean_i};
    smooth_d = env_sum[VAL_W:1];
    blend    = BL_W'(W_OLD) * BL_W'(floor_q) + BL_W'(W_NEW) * BL_W'(smooth_d)
             + BL_W'(ROUND_HALF);
    // drop straight to the envelope, otherwise creep up by the blend
    floor_d  = (floor_q > smooth_d) ? smooth_d : blend[Q_W +: VAL_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= '0;
      floor_q  <= '0;
    end else if (upd_i) begin
      smooth_q <= smooth_d;
      floor_q  <= floor_d;
    end
  end

  assign env_o  = smooth_d;
  assign base_o = floor_d;

endmodule

`default_nettype wire

// ===== hw/rtl/emg_envelope_baseline_tracker.sv =====
// Top level of the two-channel EMG envelope and baseline tracker.
// Throughput: one input transfer per clock unless the output stalls; no gaps between windows.
// The path is input register, window accumulate, mean multiply, envelope update, result register.
// Reset clears all handshake state, sums, envelopes and baselines; the offset returns to 8191.
// No clearing pass after reset: the block takes an input transfer in the first cycle out of reset.
`default_nettype none

`include "emg_envelope_baseline_tracker_assert.svh"

module emg_envelope_baseline_tracker import emgebt_pkg::*; #(
  parameter int unsigned WINDOW = 20
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [RAW_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_t              in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_t                  out_data_o
);

  // Window counter width; one bit still stands when the window is a single item.
  localparam int unsigned CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

  // Mean = (sum * 256 + WINDOW/2) / WINDOW, done as a reciprocal multiply.
  // With n below 2^N_W and a shift of N_W + clog2(WINDOW) the ceiling
  // reciprocal gives the exact quotient, so no correction step is needed.
  localparam int unsigned N_W      = SUM_W + 8 + 1;
  localparam int unsigned MUL_W    = 28;
  localparam int unsigned PROD_W   = N_W + MUL_W;
  localparam int unsigned SHIFT    = N_W + $clog2(WINDOW);
  localparam int unsigned HALF_WIN = WINDOW / 2;
  localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1)
                                        / 64'(WINDOW);
  localparam logic [MUL_W-1:0] RECIP = MUL_W'(RECIP_L);

  // Magnitude of the signed 14-bit code taken from the top of the offset word.
  function automatic logic [CODE_W-1:0] abs_code(input logic [RAW_W-1:0] diff);
    logic [CODE_W-1:0] code;
    code = diff[RAW_W-1 -: CODE_W];
    return code[CODE_W-1] ? (~code + CODE_W'(1)) : code;
  endfunction

  // Accumulate with saturation at the top of the sum range.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0]  sum,
                                               input logic [CODE_W-1:0] mag);
    logic [SUM_W:0] t;
    t = {1'b0, sum} + (SUM_W + 1)'(mag);
    return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic [RAW_W-1:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RST;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  // ------------------------------------------------------ stage handshakes
  logic in_vld_q, fin_vld_q, mean_vld_q, out_vld_q;
  logic out_free, mean_free, fin_free;
  logic last, in_take, upd;
  logic [CNT_W-1:0] cnt_q;

  assign out_free  = !out_vld_q || out_ready_i;
  assign mean_free = !mean_vld_q || out_free;
  assign fin_free  = !fin_vld_q || mean_free;
  assign upd       = mean_vld_q && out_free;

  // Mid-window items retire in the accumulate stage; only the last item of
  // a window needs room further down.
  assign last       = (cnt_q == CNT_LAST);
  assign in_take    = in_vld_q && (!last || fin_free);
  assign in_ready_o = !in_vld_q || in_take;

  // --------------------------------------------------------- input register
  in_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // ------------------------------------------------------ window accumulate
  logic [SUM_W-1:0]  sum_a_q, sum_b_q;
  logic [SUM_W-1:0]  sum_a_d, sum_b_d;
  logic [SUM_W-1:0]  fin_sum_a_q, fin_sum_b_q;

  always_comb begin
    sum_a_d = sat_add(sum_a_q, abs_code(in_q.raw_channel_a - offset_q));
    sum_b_d = sat_add(sum_b_q, abs_code(in_q.raw_channel_b - offset_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
    end else if (in_take) begin
      if (last) begin
        // window complete: hand the sums on and start afresh
        cnt_q   <= '0;
        sum_a_q <= '0;
        sum_b_q <= '0;
      end else begin
        cnt_q   <= cnt_q + CNT_W'(1);
        sum_a_q <= sum_a_d;
        sum_b_q <= sum_b_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
    end else if (fin_free) begin
      fin_vld_q <= in_take && last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && last) begin
      fin_sum_a_q <= sum_a_d;
      fin_sum_b_q <= sum_b_d;
    end
  end

  // ------------------------------------------------------------ window mean
  logic [N_W-1:0]    n_a, n_b;
  logic [PROD_W-1:0] prod_a, prod_b;
  logic [VAL_W-1:0]  mean_a_q, mean_b_q;

  always_comb begin
    n_a    = N_W'({fin_sum_a_q, 8'b0}) + N_W'(HALF_WIN);
    n_b    = N_W'({fin_sum_b_q, 8'b0}) + N_W'(HALF_WIN);
    prod_a = PROD_W'(n_a) * PROD_W'(RECIP);
    prod_b = PROD_W'(n_b) * PROD_W'(RECIP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_vld_q <= 1'b0;
    end else if (mean_free) begin
      mean_vld_q <= fin_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_vld_q && mean_free) begin
      mean_a_q <= prod_a[SHIFT +: VAL_W];
      mean_b_q <= prod_b[SHIFT +: VAL_W];
    end
  end

  // ------------------------------------------- envelope and baseline update
  logic [VAL_W-1:0] env_a, env_b, base_a, base_b;

  emgebt_track u_track_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .mean_i (mean_a_q),
    .env_o  (env_a),
    .base_o (base_a)
  );

  emgebt_track u_track_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .mean_i (mean_b_q),
    .env_o  (env_b),
    .base_o (base_b)
  );

  // -------------------------------------------------------- result register
  out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= mean_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      out_q.envelope_a <= env_a;
      out_q.envelope_b <= env_b;
      out_q.baseline_a <= base_a;
      out_q.baseline_b <= base_b;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // ------------------------------------------------------------- assertions
  `EBT_ASSERT(a_cnt_range, cnt_q <= CNT_LAST, "window counter past window end")
  `EBT_ASSERT(a_sum_clear, (in_take && last) |=> (sum_a_q == '0 && sum_b_q == '0),
              "sums not cleared after window end")
  `EBT_ASSERT(a_fin_hold, (fin_vld_q && !mean_free) |=> (fin_vld_q && $stable(fin_sum_a_q)),
              "window sum lost while mean stage stalled")
  `EBT_ASSERT(a_base_le_env, out_vld_q |-> (out_q.baseline_a <= out_q.envelope_a &&
              out_q.baseline_b <= out_q.envelope_b), "baseline above envelope")

endmodule

`default_nettype wire
